@@ hdl/hbfa_pkg.sv @@
// Shared constants, codes and types of the hashed best-fit allocator.
`default_nettype none
package hbfa_pkg;

   localparam int MAX_TILES_DEF  = 256;
   localparam int BUCKETS_DEF    = 1024;
   localparam int POOL_BYTES_DEF = 16777216;

   localparam logic [31:0] MIX_MULT    = 32'h045d9f3b;
   localparam int          MIX_SHIFT   = 16;
   localparam int          ALIGN_MASK  = 15;
   localparam logic [7:0]  HEADER_RESET = 8'd40;

   localparam int REQ_W  = 24;
   localparam int HDL_W  = 8;
   localparam int OFF_W  = 25;
   localparam int END_W  = 26;
   localparam int CNT_W  = 32;
   localparam int HDR_W  = 8;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_POOL_EXHAUSTED,
      STATUS_TABLE_FULL,
      STATUS_BAD_HANDLE
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_HASH,
      ST_SCAN,
      ST_RESP
   } state_type;

endpackage
`default_nettype wire

@@ hdl/hashed_best_fit_allocator_top.sv @@
// Top level of the hashed best-fit tile allocator with bump-pointer pool.
// Allocate: capture, the 8-step hash, then one tile per cycle through the tile record RAM
//   read port; the outcome of the scan is then loaded into the result register.
// Free: no hash or scan. One item at a time; req_tready is high only in idle, so the next
//   item waits until the last result is loaded, longer while a result waits on rsp_tready.
// Reset (synchronous) clears counters, pool pointer, tile count and sets header_bytes to 40;
// tile RAMs are not cleared, entries at or above the tile count are never read.
`default_nettype none
module hashed_best_fit_allocator_top
   import hbfa_pkg::*;
#(
   parameter int MAX_TILES  = MAX_TILES_DEF,
   parameter int BUCKETS    = BUCKETS_DEF,
   parameter int POOL_BYTES = POOL_BYTES_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_wr_en,
   input  wire logic [7:0]   csr_wr_data,    // header_bytes
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [31:0]  req_tdata,      // request_bytes[23:0], tile_handle[31:24]
   input  wire logic         req_tuser,      // func
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // granted_tile[7:0], tile_offset[32:8], data_offset[57:33], granted_bytes[82:58],
   // recycled_total[114:83], reserved_total[146:115], zero[151:147]
   output logic      [151:0] rsp_tdata,
   output logic      [2:0]   rsp_tuser       // status[1:0], was_recycled[2]
);

   localparam int IW    = $clog2(MAX_TILES);
   localparam int CW    = $clog2(MAX_TILES + 1);
   localparam int BKW   = $clog2(BUCKETS);
   localparam int REC_W = 2 * OFF_W + BKW;

   state_type state_ff, state_in;

   logic [HDR_W-1:0] header_ff, header_in;
   logic             func_ff, func_in;
   logic [OFF_W-1:0] size_ff, size_in;
   logic [HDL_W-1:0] handle_ff, handle_in;
   logic [BKW-1:0]   bucket_ff, bucket_in;
   logic [END_W-1:0] end_ff, end_in;

   logic [CW-1:0]    count_ff, count_in;
   logic [OFF_W-1:0] pool_ff, pool_in;
   logic [CNT_W-1:0] recycle_ff, recycle_in;
   logic [CNT_W-1:0] reserve_ff, reserve_in;

   logic [CW-1:0]    scan_idx_ff, scan_idx_in;
   logic             pend_ff, pend_in;
   logic [IW-1:0]    tag_ff, tag_in;
   logic             found_ff, found_in;
   logic [IW-1:0]    best_idx_ff, best_idx_in;
   logic [OFF_W-1:0] best_size_ff, best_size_in;
   logic [OFF_W-1:0] best_off_ff, best_off_in;

   logic             rsp_valid_ff, rsp_valid_in;
   status_type       out_status_ff, out_status_in;
   logic [HDL_W-1:0] out_tile_ff, out_tile_in;
   logic [OFF_W-1:0] out_toff_ff, out_toff_in;
   logic [OFF_W-1:0] out_doff_ff, out_doff_in;
   logic [OFF_W-1:0] out_bytes_ff, out_bytes_in;
   logic             out_rec_ff, out_rec_in;
   logic [CNT_W-1:0] out_rtot_ff, out_rtot_in;
   logic [CNT_W-1:0] out_vtot_ff, out_vtot_in;

   logic             hash_start, hash_done;
   logic [BKW-1:0]   hash_bucket;
   logic             scan_issue, resp_load;

   logic             used_we, used_wd;
   logic [IW-1:0]    used_wa;
   logic             rec_we;
   logic [REC_W-1:0] rec_wd, rec_rd;
   logic [0:0]       used_rd;

   logic [OFF_W-1:0] rd_size, rd_off;
   logic [BKW-1:0]   rd_bucket;
   logic             hit;
   logic             handle_bad, table_full, pool_over;
   logic [IW-1:0]    handle_idx, count_idx;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = (req_tuser == FUNC_FREE) ? ST_RESP : ST_START;
            end
         end
         ST_START: begin
            state_in = ST_HASH;
         end
         ST_HASH: begin
            if (hash_done) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!scan_issue && !pend_ff) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (resp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control outputs
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      hash_start = (state_ff == ST_START);
      scan_issue = (state_ff == ST_SCAN) && (scan_idx_ff < count_ff);
      resp_load  = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_tready);
   end

   hbfa_hash #(
      .BUCKETS (BUCKETS)
   ) u_hash (
      .clock  (clock),
      .reset  (reset),
      .start  (hash_start),
      .value  (32'(size_ff)),
      .done   (hash_done),
      .bucket (hash_bucket)
   );

   hbfa_ram #(
      .WIDTH (REC_W),
      .DEPTH (MAX_TILES)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (rec_we),
      .wr_addr (count_idx),
      .wr_data (rec_wd),
      .rd_en   (scan_issue),
      .rd_addr (scan_idx_ff[IW-1:0]),
      .rd_data (rec_rd)
   );

   hbfa_ram #(
      .WIDTH (1),
      .DEPTH (MAX_TILES)
   ) u_used_ram (
      .clock   (clock),
      .wr_en   (used_we),
      .wr_addr (used_wa),
      .wr_data (used_wd),
      .rd_en   (scan_issue),
      .rd_addr (scan_idx_ff[IW-1:0]),
      .rd_data (used_rd)
   );

   assign rd_size   = rec_rd[OFF_W-1:0];
   assign rd_bucket = rec_rd[OFF_W+BKW-1:OFF_W];
   assign rd_off    = rec_rd[REC_W-1:OFF_W+BKW];
   assign hit = pend_ff && (rd_bucket == bucket_ff) && !used_rd[0] && (rd_size >= size_ff)
                && (!found_ff || (rd_size < best_size_ff));

   // request capture, hashing and scan
   always_comb begin
      header_in    = csr_wr_en ? csr_wr_data : header_ff;
      func_in      = func_ff;
      size_in      = size_ff;
      handle_in    = handle_ff;
      bucket_in    = bucket_ff;
      end_in       = end_ff;
      scan_idx_in  = scan_idx_ff;
      pend_in      = 1'b0;
      tag_in       = tag_ff;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_size_in = best_size_ff;
      best_off_in  = best_off_ff;
      if (req_tvalid && req_tready) begin
         func_in   = req_tuser;
         size_in   = (OFF_W'(req_tdata[REQ_W-1:0]) + OFF_W'(ALIGN_MASK))
                     & ~OFF_W'(ALIGN_MASK);
         handle_in = req_tdata[REQ_W+HDL_W-1:REQ_W];
      end
      if (state_ff == ST_START) begin
         end_in = END_W'(pool_ff) + END_W'(header_ff) + END_W'(size_ff);
      end
      if (state_ff == ST_HASH && hash_done) begin
         bucket_in   = hash_bucket;
         scan_idx_in = '0;
         found_in    = 1'b0;
      end
      if (state_ff == ST_SCAN) begin
         pend_in = scan_issue;
         tag_in  = scan_idx_ff[IW-1:0];
         if (scan_issue) begin
            scan_idx_in = scan_idx_ff + CW'(1);
         end
         if (hit) begin
            found_in     = 1'b1;
            best_idx_in  = tag_ff;
            best_size_in = rd_size;
            best_off_in  = rd_off;
         end
      end
   end

   // result and table update
   always_comb begin
      handle_idx = IW'(32'(handle_ff));
      count_idx  = count_ff[IW-1:0];
      handle_bad = 32'(handle_ff) >= 32'(count_ff);
      table_full = (count_ff == CW'(MAX_TILES));
      pool_over  = end_ff > END_W'(POOL_BYTES);

      out_status_in = STATUS_OK;
      out_tile_in   = '0;
      out_toff_in   = '0;
      out_doff_in   = '0;
      out_bytes_in  = '0;
      out_rec_in    = 1'b0;
      used_wa       = handle_idx;
      used_wd       = 1'b0;
      used_we       = 1'b0;
      rec_we        = 1'b0;
      rec_wd        = {pool_ff, bucket_ff, size_ff};
      count_in      = count_ff;
      pool_in       = pool_ff;
      recycle_in    = recycle_ff;
      reserve_in    = reserve_ff;

      priority if (func_ff == FUNC_FREE) begin
         if (handle_bad) begin
            out_status_in = STATUS_BAD_HANDLE;
         end else begin
            used_we = 1'b1;
         end
      end else if (found_ff) begin
         out_tile_in  = HDL_W'(best_idx_ff);
         out_toff_in  = best_off_ff;
         out_doff_in  = best_off_ff + OFF_W'(header_ff);
         out_bytes_in = best_size_ff;
         out_rec_in   = 1'b1;
         used_wa      = best_idx_ff;
         used_wd      = 1'b1;
         used_we      = 1'b1;
         recycle_in   = recycle_ff + CNT_W'(1);
      end else if (table_full) begin
         out_status_in = STATUS_TABLE_FULL;
      end else if (pool_over) begin
         out_status_in = STATUS_POOL_EXHAUSTED;
      end else begin
         out_tile_in  = HDL_W'(count_idx);
         out_toff_in  = pool_ff;
         out_doff_in  = pool_ff + OFF_W'(header_ff);
         out_bytes_in = size_ff;
         used_wa      = count_idx;
         used_wd      = 1'b1;
         used_we      = 1'b1;
         rec_we       = 1'b1;
         count_in     = count_ff + CW'(1);
         pool_in      = end_ff[OFF_W-1:0];
         reserve_in   = reserve_ff + CNT_W'(1);
      end

      used_we     = used_we && resp_load;
      rec_we      = rec_we && resp_load;
      out_rtot_in = recycle_in;
      out_vtot_in = reserve_in;

      if (resp_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_tready;
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      size_ff      <= size_in;
      handle_ff    <= handle_in;
      bucket_ff    <= bucket_in;
      end_ff       <= end_in;
      scan_idx_ff  <= scan_idx_in;
      tag_ff       <= tag_in;
      best_idx_ff  <= best_idx_in;
      best_size_ff <= best_size_in;
      best_off_ff  <= best_off_in;
      if (resp_load) begin
         out_status_ff <= out_status_in;
         out_tile_ff   <= out_tile_in;
         out_toff_ff   <= out_toff_in;
         out_doff_ff   <= out_doff_in;
         out_bytes_ff  <= out_bytes_in;
         out_rec_ff    <= out_rec_in;
         out_rtot_ff   <= out_rtot_in;
         out_vtot_ff   <= out_vtot_in;
      end
      if (reset) begin
         state_ff     <= ST_IDLE;
         header_ff    <= HEADER_RESET;
         count_ff     <= '0;
         pool_ff      <= '0;
         recycle_ff   <= '0;
         reserve_ff   <= '0;
         pend_ff      <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         header_ff    <= header_in;
         pend_ff      <= pend_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         if (resp_load) begin
            count_ff   <= count_in;
            pool_ff    <= pool_in;
            recycle_ff <= recycle_in;
            reserve_ff <= reserve_in;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {out_rec_ff, out_status_ff};
   assign rsp_tdata  = {5'b0, out_vtot_ff, out_rtot_ff, out_bytes_ff, out_doff_ff,
                        out_toff_ff, out_tile_ff};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(MAX_TILES))
      else $error("tile count past table depth");

   a_pool_bound: assert property (@(posedge clock) disable iff (reset)
      32'(pool_ff) <= 32'(POOL_BYTES))
      else $error("pool pointer past pool end");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      resp_load && out_status_in == STATUS_TABLE_FULL |-> table_full)
      else $error("table full reported with free entries");

   a_recycle_count: assert property (@(posedge clock) disable iff (reset)
      resp_load && func_ff == FUNC_ALLOC && found_ff
      |=> recycle_ff == $past(recycle_ff) + CNT_W'(1))
      else $error("recycle count did not advance");

   a_scan_tag: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> 32'(tag_ff) < 32'(count_ff))
      else $error("scan read beyond created tiles");

endmodule
`default_nettype wire

@@ hdl/hbfa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module hbfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ hdl/hbfa_hash.sv @@
// Iterative size hash: two xor-multiply rounds, final xor, modulo by reciprocal multiply.
`default_nettype none
module hbfa_hash
   import hbfa_pkg::*;
#(
   parameter int BUCKETS = BUCKETS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [31:0]                value,
   output logic                            done,
   output logic      [$clog2(BUCKETS)-1:0] bucket
);

   localparam int BKW = $clog2(BUCKETS);

   // q = (t + ((x - t) >> 1)) >> (BKW - 1), t = high half of x * RECIP
   localparam logic [31:0] RECIP =
      32'((((64'd1 << 32) * 64'((1 << BKW) - BUCKETS)) / 64'(BUCKETS)) + 64'd1);

   localparam logic [2:0] STEP_MUL_A = 3'd1;
   localparam logic [2:0] STEP_MUL_B = 3'd3;
   localparam logic [2:0] STEP_RECIP = 3'd5;
   localparam logic [2:0] STEP_QUOT  = 3'd6;
   localparam logic [2:0] STEP_LAST  = 3'd7;

   logic [31:0]    x_ff, x_in;
   logic [31:0]    aux_ff, aux_in;
   logic [BKW-1:0] rem_ff, rem_in;
   logic [2:0]     step_ff, step_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [31:0]    mul_a, mul_b;
   logic [63:0]    product;

   always_comb begin
      x_in    = x_ff;
      aux_in  = aux_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      mul_a   = (step_ff == STEP_LAST) ? aux_ff : x_ff;
      if (step_ff == STEP_RECIP) begin
         mul_b = RECIP;
      end else if (step_ff == STEP_LAST) begin
         mul_b = 32'(BUCKETS);
      end else begin
         mul_b = MIX_MULT;
      end
      product = 64'(mul_a) * 64'(mul_b);
      if (start) begin
         x_in    = value;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         unique case (step_ff)
            STEP_MUL_A, STEP_MUL_B: begin
               x_in = product[31:0];
            end
            STEP_RECIP: begin
               aux_in = product[63:32];
            end
            STEP_QUOT: begin
               aux_in = (aux_ff + ((x_ff - aux_ff) >> 1)) >> (BKW - 1);
            end
            STEP_LAST: begin
               rem_in = BKW'(x_ff - product[31:0]);
            end
            default: begin
               x_in = x_ff ^ (x_ff >> MIX_SHIFT);
            end
         endcase
         if (step_ff == STEP_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      aux_ff <= aux_in;
      rem_ff <= rem_in;
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done   = done_ff;
   assign bucket = rem_ff;

endmodule
`default_nettype wire

@@ sim/tb_hashed_best_fit_allocator_top.sv @@
// Self-checking testbench for the hashed best-fit tile allocator top level.
`timescale 1ns / 100ps
module tb_hashed_best_fit_allocator_top;
   import hbfa_pkg::*;

   localparam int CYCLE_LIMIT = 2_000_000;

   typedef struct {
      status_type   status;
      logic [7:0]   tile;
      logic [24:0]  tile_off;
      logic [24:0]  data_off;
      logic [24:0]  bytes;
      logic         recycled;
      logic [31:0]  recycled_total;
      logic [31:0]  reserved_total;
   } grant_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          csr_wr_en = 1'b0;
   logic [7:0]    csr_wr_data = 8'd0;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [31:0]   req_tdata = 32'd0;
   logic          req_tuser = 1'b0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [151:0]  rsp_tdata;
   logic [2:0]    rsp_tuser;

   hashed_best_fit_allocator_top dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // allocator shadow state
   logic [24:0]  tile_size_q [MAX_TILES_DEF];
   logic         tile_busy_q [MAX_TILES_DEF];
   logic [9:0]   tile_bucket_q [MAX_TILES_DEF];
   logic [24:0]  tile_base_q [MAX_TILES_DEF];
   int           tiles_made = 0;
   logic [31:0]  pool_top = 0;
   logic [31:0]  reuse_count = 0;
   logic [31:0]  carve_count = 0;
   logic [7:0]   header_len = HEADER_RESET;

   grant_type    grants_due [$];
   grant_type    last_grant;
   grant_type    got_grant;
   int           errors = 0;
   int           items_sent = 0;
   int           status_seen [4] = '{0, 0, 0, 0};
   int           recycled_seen = 0;
   int           burst_left = 0;
   int           cycle_count = 0;
   int           stall_mode = 0;
   int           stall_left = 0;

   initial begin
      for (int i = 0; i < MAX_TILES_DEF; i++) tile_busy_q[i] = 1'b0;
   end

   function automatic logic [9:0] size_bucket(logic [31:0] v);
      logic [31:0] x;
      x = v;
      x = ((x >> MIX_SHIFT) ^ x) * MIX_MULT;
      x = ((x >> MIX_SHIFT) ^ x) * MIX_MULT;
      x = (x >> MIX_SHIFT) ^ x;
      return 10'(x % BUCKETS_DEF);
   endfunction

   function automatic grant_type compute_grant(logic func, logic [23:0] req, logic [7:0] hdl);
      grant_type   g;
      logic [31:0] sz;
      logic [9:0]  bkt;
      logic [31:0] pool_end;
      bit          found;
      int          best;
      logic [24:0] lowest;
      g = '{STATUS_OK, 8'd0, 25'd0, 25'd0, 25'd0, 1'b0, 32'd0, 32'd0};
      found = 1'b0;
      best = 0;
      lowest = '0;
      if (func == FUNC_FREE) begin
         if (int'(hdl) >= tiles_made) g.status = STATUS_BAD_HANDLE;
         else tile_busy_q[hdl] = 1'b0;
      end else begin
         sz = ({8'd0, req} + 32'd15) & ~32'd15;
         bkt = size_bucket(sz);
         for (int i = 0; i < tiles_made; i++) begin
            if (tile_bucket_q[i] == bkt && !tile_busy_q[i] && tile_size_q[i] >= sz[24:0] &&
                (!found || tile_size_q[i] < lowest)) begin
               found = 1'b1;
               best = i;
               lowest = tile_size_q[i];
            end
         end
         pool_end = pool_top + header_len + sz;
         if (found) begin
            tile_busy_q[best] = 1'b1;
            reuse_count++;
            g.tile = best[7:0];
            g.tile_off = tile_base_q[best];
            g.data_off = tile_base_q[best] + header_len;
            g.bytes = tile_size_q[best];
            g.recycled = 1'b1;
         end else if (tiles_made >= MAX_TILES_DEF) begin
            g.status = STATUS_TABLE_FULL;
         end else if (pool_end > POOL_BYTES_DEF) begin
            g.status = STATUS_POOL_EXHAUSTED;
         end else begin
            tile_size_q[tiles_made] = sz[24:0];
            tile_bucket_q[tiles_made] = bkt;
            tile_base_q[tiles_made] = pool_top[24:0];
            tile_busy_q[tiles_made] = 1'b1;
            g.tile = tiles_made[7:0];
            g.tile_off = pool_top[24:0];
            g.data_off = pool_top[24:0] + header_len;
            g.bytes = sz[24:0];
            tiles_made++;
            pool_top = pool_end;
            carve_count++;
         end
      end
      g.recycled_total = reuse_count;
      g.reserved_total = carve_count;
      return g;
   endfunction

   task automatic send_item(logic func, logic [23:0] req, logic [7:0] hdl);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= {hdl, req};
      req_tuser <= func;
      last_grant = compute_grant(func, req, hdl);
      grants_due.push_back(last_grant);
      items_sent++;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (grants_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_header(logic [7:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      header_len = v;
   endtask

   task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         errors++;
      end
   endtask

   // receiver stall pattern
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(20, 300);
      end
      stall_left--;
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (grants_due.size() == 0) begin
            $display("%0t: result with nothing expected, actual tdata %0h tuser %0h",
                     $time, rsp_tdata, rsp_tuser);
            errors++;
         end else begin
            got_grant = grants_due.pop_front();
            report_field("status", got_grant.status, rsp_tuser[1:0]);
            report_field("was_recycled", got_grant.recycled, rsp_tuser[2]);
            report_field("granted_tile", got_grant.tile, rsp_tdata[7:0]);
            report_field("tile_offset", got_grant.tile_off, rsp_tdata[32:8]);
            report_field("data_offset", got_grant.data_off, rsp_tdata[57:33]);
            report_field("granted_bytes", got_grant.bytes, rsp_tdata[82:58]);
            report_field("recycled_total", got_grant.recycled_total, rsp_tdata[114:83]);
            report_field("reserved_total", got_grant.reserved_total, rsp_tdata[146:115]);
            status_seen[rsp_tuser[1:0]]++;
            if (rsp_tuser[2]) recycled_seen++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results still expected", $time, grants_due.size());
         $display("** hashed_best_fit_allocator_top: FAILED **");
         $finish;
      end
   end

   task automatic test_directed_basics();
      send_item(FUNC_ALLOC, 24'd0, 8'hFF);           // zero-byte, tile 0
      send_item(FUNC_ALLOC, 24'hFFFFFF, 8'hFF);      // pool exhausted
      send_item(FUNC_ALLOC, 24'd1, 8'h00);           // tile 1, size 16
      send_item(FUNC_FREE, 24'hFFFFFF, 8'd200);      // uncreated handle
      send_item(FUNC_FREE, 24'd0, 8'd2);             // first uncreated handle
      send_item(FUNC_FREE, 24'd0, 8'd1);
      send_item(FUNC_FREE, 24'd0, 8'd1);             // already free
      send_item(FUNC_ALLOC, 24'd16, 8'd0);           // reuses tile 1
      send_item(FUNC_ALLOC, 24'd0, 8'd0);            // tile 0 busy, new tile
      send_item(FUNC_FREE, 24'd0, 8'd0);
      send_item(FUNC_ALLOC, 24'd0, 8'd0);            // zero-byte reuse
      wait_idle();
   endtask

   task automatic test_best_fit();
      int first_k [BUCKETS_DEF];
      int second_k [BUCKETS_DEF];
      int sa, sb, sc;
      logic [9:0] b;
      logic [7:0] tx, ty, tz;
      sa = 0;
      sb = 0;
      sc = 0;
      for (int i = 0; i < BUCKETS_DEF; i++) begin
         first_k[i] = 0;
         second_k[i] = 0;
      end
      // three aligned sizes sharing one bucket
      for (int k = 1; k < 4096 && sc == 0; k++) begin
         b = size_bucket(32'(16 * k));
         if (first_k[b] == 0) first_k[b] = k;
         else if (second_k[b] == 0) second_k[b] = k;
         else begin
            sa = 16 * first_k[b];
            sb = 16 * second_k[b];
            sc = 16 * k;
         end
      end
      send_item(FUNC_ALLOC, 24'(sc - $urandom_range(0, 15)), 8'd0);
      tx = last_grant.tile;
      send_item(FUNC_ALLOC, 24'(sb - $urandom_range(0, 15)), 8'd0);
      ty = last_grant.tile;
      send_item(FUNC_ALLOC, 24'(sb), 8'd0);
      tz = last_grant.tile;
      send_item(FUNC_FREE, 24'd0, tx);
      send_item(FUNC_FREE, 24'd0, ty);
      send_item(FUNC_FREE, 24'd0, tz);
      repeat (3) send_item(FUNC_ALLOC, 24'(sa - $urandom_range(0, 15)), 8'd0);
      wait_idle();
      write_header(8'd255);
      send_item(FUNC_FREE, 24'd0, ty);
      send_item(FUNC_ALLOC, 24'(sa), 8'd0);          // data offset with new header
      send_item(FUNC_ALLOC, 24'hFFFFFF, 8'd0);
      wait_idle();
   endtask

   task automatic test_random_mix(int n);
      int r;
      int unsigned al;
      logic [23:0] rq;
      logic [7:0] hd;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         rq = 24'($urandom);
         hd = 8'($urandom);
         if (r < 38) begin
            if (r >= 3 && tiles_made > 0) hd = 8'($urandom_range(0, tiles_made - 1));
            send_item(FUNC_FREE, rq, hd);
         end else begin
            if (r < 95) begin
               al = 16 * $urandom_range(0, 40);
               rq = (al == 0) ? 24'd0 : 24'(al - $urandom_range(0, 15));
            end else if (r < 97) begin
               rq[23] = 1'b1;
            end
            send_item(FUNC_ALLOC, rq, hd);
         end
      end
      wait_idle();
   endtask

   task automatic test_random_phases();
      logic [7:0] headers [4];
      headers = '{8'd40, 8'd0, 8'd255, 8'($urandom)};
      foreach (headers[p]) begin
         write_header(headers[p]);
         test_random_mix(230);
      end
   endtask

   task automatic test_table_full();
      int guard;
      guard = 0;
      write_header(8'd0);
      // size 0 with no header always fits the pool
      while (tiles_made < MAX_TILES_DEF && guard < 400) begin
         send_item(FUNC_ALLOC, 24'd0, 8'($urandom));
         guard++;
      end
      repeat (8) send_item(FUNC_ALLOC, 24'(16 * $urandom_range(41, 4000)), 8'($urandom));
      wait_idle();
      write_header(8'($urandom));
      test_random_mix(80);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_basics();
      test_best_fit();
      test_random_phases();
      test_table_full();
      wait_idle();
      repeat (40) @(posedge clock);
      $display("Ran %0d items over %0d tiles: %0d ok (%0d recycled), %0d pool exhausted,",
               items_sent, tiles_made, status_seen[STATUS_OK], recycled_seen,
               status_seen[STATUS_POOL_EXHAUSTED]);
      $display("%0d table full, %0d bad handle, header settings 40/0/255/random",
               status_seen[STATUS_TABLE_FULL], status_seen[STATUS_BAD_HANDLE]);
      if (errors == 0) $display("** hashed_best_fit_allocator_top: PASSED **");
      else $display("** hashed_best_fit_allocator_top: FAILED **");
      $finish;
   end

endmodule
